// ===== hw/rtl/fltw_pkg.sv =====
package fltw_pkg;

  localparam int unsigned StorePages   = 64;
  localparam int unsigned PageBits     = $clog2(StorePages);
  localparam int unsigned IndexBits    = 9;
  localparam int unsigned Levels       = 4;
  localparam int unsigned LevelBits    = $clog2(Levels + 1);
  localparam int unsigned AddrBits     = PageBits + IndexBits;
  localparam int unsigned EntryBits    = 64;
  localparam int unsigned FrameBits    = 40;
  localparam int unsigned VpageBits    = 35;
  localparam int unsigned PageShift    = 12;
  localparam int unsigned ClearCntBits = IndexBits;

  localparam logic [EntryBits-1:0] AttrPresent  = 64'h1;
  localparam logic [EntryBits-1:0] AttrWritable = 64'h2;
  localparam logic [EntryBits-1:0] AttrUser     = 64'h4;

  typedef enum logic [1:0] {
    OP_MAP     = 2'd0,
    OP_UNMAP   = 2'd1,
    OP_RESOLVE = 2'd2,
    OP_UNUSED  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TRY_AGAIN = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_CLEAR,
    S_LINK,
    S_DONE
  } state_e;

  function automatic logic [IndexBits-1:0] level_index(
    input logic [VpageBits-1:0] vpage,
    input logic [LevelBits-1:0] level
  );
    logic [EntryBits-1:0] wide;
    int unsigned sh;
    wide = EntryBits'(vpage);
    sh = IndexBits * (int'(level) - 1);
    if (sh >= EntryBits) begin
      return '0;
    end
    return IndexBits'(wide >> sh);
  endfunction

endpackage

// ===== hw/rtl/fltw_ram.sv =====
module fltw_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hw/rtl/four_level_page_table_walk_core.sv =====
// Four-level page table walker over a local 64-page table store (32768 x 64-bit RAM,
// one read and one write port, registered read). After reset the block sweeps the whole
// store to zero, one entry a cycle, with stall_o high. Each table level visited passes
// through a read state and then an evaluate state that may write the entry back, and a
// done state then marks the result register valid. stall_o stays high until the result
// is taken, so the next item is accepted only after the previous result has been taken.
// A map that installs a missing table clears the spare page first and then writes the
// link. One item is in flight at a time; the result register frees stall_o once taken.
module four_level_page_table_walk_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            stall_o,
  input  logic [1:0]                      operation_i,
  input  logic [5:0]                      root_page_i,
  input  logic [fltw_pkg::VpageBits-1:0]  virtual_page_i,
  input  logic [fltw_pkg::FrameBits-1:0]  frame_i,
  input  logic                            writable_i,
  input  logic [5:0]                      spare_page_i,
  output logic                            valid_o,
  input  logic                            stall_i,
  output logic [1:0]                      status_o,
  output logic [fltw_pkg::FrameBits-1:0]  resolved_frame_o,
  output logic                            flush_request_o
);

  localparam int unsigned Depth = fltw_pkg::StorePages * (2 ** fltw_pkg::IndexBits);
  localparam int unsigned DBits = fltw_pkg::AddrBits;

  fltw_pkg::state_e state_q, state_d;
  logic [DBits-1:0]                     init_q, init_d;
  logic [fltw_pkg::ClearCntBits-1:0]    clr_q, clr_d;
  logic [fltw_pkg::LevelBits-1:0]       lvl_q, lvl_d;
  logic [fltw_pkg::PageBits-1:0]        page_q, page_d;
  logic [1:0]                           op_q, op_d;
  logic [fltw_pkg::VpageBits-1:0]       vp_q, vp_d;
  logic [fltw_pkg::FrameBits-1:0]       fr_q, fr_d;
  logic                                 wr_q, wr_d;
  logic [5:0]                           spare_q, spare_d;
  logic                                 ovalid_q, ovalid_d;
  logic [1:0]                           ost_q, ost_d;
  logic [fltw_pkg::FrameBits-1:0]       ofr_q, ofr_d;
  logic                                 ofl_q, ofl_d;

  logic                         we;
  logic [DBits-1:0]             waddr, raddr, cur_addr;
  logic [fltw_pkg::EntryBits-1:0] wdata, rdata, attrs, upd;

  fltw_ram #(.Width(fltw_pkg::EntryBits), .Depth(Depth)) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign cur_addr = {page_q, fltw_pkg::level_index(vp_q, lvl_q)};
  assign attrs = (op_q == fltw_pkg::OP_MAP) ?
                 (fltw_pkg::AttrPresent | fltw_pkg::AttrUser |
                  (wr_q ? fltw_pkg::AttrWritable : '0)) : '0;
  assign upd = rdata | attrs;

  assign stall_o  = (state_q != fltw_pkg::S_IDLE) || ovalid_q;
  assign valid_o  = ovalid_q;
  assign status_o = ost_q;
  assign resolved_frame_o = ofr_q;
  assign flush_request_o  = ofl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fltw_pkg::S_INIT;
      init_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      init_q   <= init_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    clr_q   <= clr_d;
    lvl_q   <= lvl_d;
    page_q  <= page_d;
    op_q    <= op_d;
    vp_q    <= vp_d;
    fr_q    <= fr_d;
    wr_q    <= wr_d;
    spare_q <= spare_d;
    ost_q   <= ost_d;
    ofr_q   <= ofr_d;
    ofl_q   <= ofl_d;
  end

  always_comb begin
    state_d  = state_q;
    init_d   = init_q;
    clr_d    = clr_q;
    lvl_d    = lvl_q;
    page_d   = page_q;
    op_d     = op_q;
    vp_d     = vp_q;
    fr_d     = fr_q;
    wr_d     = wr_q;
    spare_d  = spare_q;
    ovalid_d = ovalid_q && stall_i;
    ost_d    = ost_q;
    ofr_d    = ofr_q;
    ofl_d    = ofl_q;
    we       = 1'b0;
    waddr    = cur_addr;
    wdata    = '0;
    raddr    = cur_addr;
    case (state_q)
      fltw_pkg::S_INIT: begin
        we     = 1'b1;
        waddr  = init_q[DBits-1:0];
        init_d = init_q + 1'b1;
        if (init_q[DBits-1:0] == DBits'(Depth - 1)) begin
          state_d = fltw_pkg::S_IDLE;
        end
      end
      fltw_pkg::S_IDLE: begin
        if (valid_i && !stall_o) begin
          op_d    = operation_i;
          page_d  = fltw_pkg::PageBits'(root_page_i % fltw_pkg::StorePages);
          vp_d    = virtual_page_i;
          fr_d    = frame_i;
          wr_d    = writable_i;
          spare_d = spare_page_i;
          lvl_d   = fltw_pkg::LevelBits'(fltw_pkg::Levels);
          if (operation_i == fltw_pkg::OP_UNUSED) begin
            ost_d    = fltw_pkg::ST_OK;
            ofr_d    = '0;
            ofl_d    = 1'b0;
            state_d  = fltw_pkg::S_DONE;
          end else begin
            state_d = fltw_pkg::S_READ;
          end
        end
      end
      fltw_pkg::S_READ: begin
        state_d = fltw_pkg::S_EVAL;
      end
      fltw_pkg::S_EVAL: begin
        ost_d = fltw_pkg::ST_OK;
        ofr_d = '0;
        ofl_d = 1'b0;
        if (lvl_q == fltw_pkg::LevelBits'(1)) begin
          state_d = fltw_pkg::S_DONE;
          case (op_q)
            fltw_pkg::OP_MAP: begin
              we    = 1'b1;
              wdata = (fltw_pkg::EntryBits'(fr_q) << fltw_pkg::PageShift) | attrs;
              ofl_d = 1'b1;
            end
            fltw_pkg::OP_UNMAP: begin
              we    = 1'b1;
              ofl_d = 1'b1;
            end
            default: begin
              ofr_d = fltw_pkg::FrameBits'(rdata >> fltw_pkg::PageShift);
            end
          endcase
        end else if (rdata == '0) begin
          state_d = fltw_pkg::S_DONE;
          case (op_q)
            fltw_pkg::OP_MAP: begin
              if (spare_q != '0) begin
                clr_d   = '0;
                state_d = fltw_pkg::S_CLEAR;
              end else begin
                ost_d = fltw_pkg::ST_EMPTY;
              end
            end
            fltw_pkg::OP_UNMAP: ost_d = fltw_pkg::ST_NOT_FOUND;
            default: ost_d = fltw_pkg::ST_OK;
          endcase
        end else begin
          we      = 1'b1;
          wdata   = upd;
          page_d  = fltw_pkg::PageBits'(upd >> fltw_pkg::PageShift);
          lvl_d   = lvl_q - 1'b1;
          state_d = fltw_pkg::S_READ;
        end
      end
      fltw_pkg::S_CLEAR: begin
        we    = 1'b1;
        waddr = {fltw_pkg::PageBits'(spare_q % fltw_pkg::StorePages),
                 clr_q[fltw_pkg::IndexBits-1:0]};
        clr_d = clr_q + 1'b1;
        if (clr_q[fltw_pkg::IndexBits-1:0] == '1) begin
          state_d = fltw_pkg::S_LINK;
        end
      end
      fltw_pkg::S_LINK: begin
        we      = 1'b1;
        wdata   = fltw_pkg::EntryBits'(spare_q) << fltw_pkg::PageShift;
        ost_d   = fltw_pkg::ST_TRY_AGAIN;
        state_d = fltw_pkg::S_DONE;
      end
      fltw_pkg::S_DONE: begin
        ovalid_d = 1'b1;
        state_d  = fltw_pkg::S_IDLE;
      end
      default: state_d = fltw_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != fltw_pkg::S_IDLE) |-> stall_o)
    else $error("accept while busy");
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> (valid_o && $stable(status_o) && $stable(flush_request_o)))
    else $error("result changed under stall");
  a_flush_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && flush_request_o) |-> (status_o == fltw_pkg::ST_OK))
    else $error("flush with error status");
  a_link_after_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fltw_pkg::S_LINK) |-> ($past(state_q) == fltw_pkg::S_CLEAR))
    else $error("link without clear");
`endif

endmodule
